// ----- hdl/mcbae_pkg.sv -----
// Shared types, constants and helper functions for the mixed-count binary
// arithmetic encoder. No dependencies.
`default_nettype none

package mcbae_pkg;

    localparam int COUNTER_ROWS  = 16;
    localparam int NODES_PER_ROW = 256;
    localparam int ENTRY_COUNT   = COUNTER_ROWS * NODES_PER_ROW;
    localparam int ENTRY_W       = $clog2(ENTRY_COUNT);

    localparam int ROW_W   = 4;
    localparam int NODE_W  = 8;
    localparam int WGT_W   = 5;
    localparam int CNT_W   = 14;
    localparam int PROB_W  = 13;

    localparam int WEIGHT_FULL = 32;
    localparam int PROB_ONE    = 4096;
    localparam int HALVE_LIMIT = 8192;
    localparam int CNT_INIT    = 32;

    localparam logic FUNC_CODE  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // one queued transaction, already reduced to store addresses
    typedef struct packed {
        logic               func;
        logic               bin;
        logic [ENTRY_W-1:0] idx_a;
        logic [ENTRY_W-1:0] idx_b;
        logic [WGT_W-1:0]   wgt;
    } t_job;

    typedef struct packed {
        logic [CNT_W-1:0] c1;
        logic [CNT_W-1:0] c0;
    } t_pair;

    // v mod m by restoring reduction, m >= 1
    function automatic logic [7:0] wrap8(logic [7:0] v, int unsigned m);
        logic [7:0] t;
        t = v;
        for (int k = 7; k >= 0; k--) begin
            if (32'(t) >= (m << k)) begin
                t = t - 8'(m << k);
            end
        end
        return t;
    endfunction

    function automatic t_pair cnt_update(t_pair p, logic bin, logic [5:0] wt);
        logic [CNT_W:0] c0;
        logic [CNT_W:0] c1;
        t_pair          r;
        c0 = {1'b0, p.c0};
        c1 = {1'b0, p.c1};
        if (bin) begin
            c1 = c1 + (CNT_W+1)'(wt);
        end else begin
            c0 = c0 + (CNT_W+1)'(wt);
        end
        if ((16'(c0) + 16'(c1)) > 16'(HALVE_LIMIT)) begin
            c0 = (c0 + 1'b1) >> 1;
            c1 = (c1 + 1'b1) >> 1;
        end
        r.c0 = c0[CNT_W-1:0];
        r.c1 = c1[CNT_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mixed_count_binary_arith_encoder.sv -----
// Binary arithmetic encoder with mixed count-based estimates, top level.
// Uses mcbae_pkg, mcbae_front and mcbae_back.
//
// After reset the block sweeps its 4096-entry counter store to 32/32, one
// entry a cycle, so s_axis_tready stays low (queue aside) until the sweep
// is done and the first transaction is worked on. A coding transaction
// runs two store reads, two 13-step bit-serial dividers running side by
// side for the estimates, a blend, a range split, renormalisation, which
// emits its bytes and waits while the output is stalled, and two counter
// write-backs. A flush emits the four bytes of the low bound, high byte
// first.
// A two-entry queue in front lets the sender run ahead, and one output
// register decouples the result stream.
`default_nettype none

module mixed_count_binary_arith_encoder import mcbae_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // bin_value[0], row_first[4:1], row_second[8:5], node_index[16:9],
    // mix_weight[21:17], zero pad [23:22]
    input  wire logic [23:0] s_axis_tdata,
    // func[0]: 0 code a bin, 1 flush
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]       m_axis_tdata,
    // last_byte: last byte of this transaction
    output logic             m_axis_tlast
);

    t_job job;
    logic job_valid;
    logic job_pop;

    mcbae_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_job         (job),
        .o_job_valid   (job_valid),
        .i_job_pop     (job_pop)
    );

    mcbae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- hdl/mcbae_front.sv -----
// Input side: accepts stream transactions, wraps row/node into store
// addresses and holds them in a two-entry queue. Depends on mcbae_pkg.
`default_nettype none

module mcbae_front import mcbae_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    output t_job             o_job,
    output logic             o_job_valid,
    input  wire logic        i_job_pop
);

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_job       n_job;
    logic       push;
    logic [7:0] row_a;
    logic [7:0] row_b;
    logic [7:0] node;

    always_comb begin
        row_a = wrap8({4'b0, s_axis_tdata[4:1]}, COUNTER_ROWS);
        row_b = wrap8({4'b0, s_axis_tdata[8:5]}, COUNTER_ROWS);
        node  = wrap8(s_axis_tdata[16:9], NODES_PER_ROW);
        n_job.func  = s_axis_tuser;
        n_job.bin   = s_axis_tdata[0];
        n_job.idx_a = ENTRY_W'(row_a) * ENTRY_W'(NODES_PER_ROW) + ENTRY_W'(node);
        n_job.idx_b = ENTRY_W'(row_b) * ENTRY_W'(NODES_PER_ROW) + ENTRY_W'(node);
        n_job.wgt   = s_axis_tdata[21:17];
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_job_valid   = (r_cnt != 2'd0);
    assign o_job         = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop && o_job_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_job_pop && o_job_valid);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mcbae_back.sv -----
// Coding engine: counter store, two bit-serial dividers, blend, range split,
// renormalisation and output register. Depends on mcbae_pkg.
`default_nettype none

module mcbae_back import mcbae_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_job       i_job,
    input  wire logic       i_job_valid,
    output logic            o_job_pop,
    output logic            o_tvalid,
    input  wire logic       i_tready,
    output logic [7:0]      o_tdata,
    output logic            o_tlast
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RDA    = 4'd2;
    localparam logic [3:0] S_RDB    = 4'd3;
    localparam logic [3:0] S_DINIT  = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_BLEND  = 4'd7;
    localparam logic [3:0] S_SPLIT  = 4'd8;
    localparam logic [3:0] S_MID    = 4'd9;
    localparam logic [3:0] S_RENORM = 4'd10;
    localparam logic [3:0] S_UPDA   = 4'd11;
    localparam logic [3:0] S_UPDB   = 4'd12;
    localparam logic [3:0] S_FLUSH  = 4'd13;

    t_pair              r_mem [ENTRY_COUNT];
    t_pair              r_rd_data;
    logic [ENTRY_W-1:0] rd_addr;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_addr;
    t_pair              wr_data;

    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic [ENTRY_W-1:0] r_clr;
    t_job               r_job;
    t_pair              r_ca;
    t_pair              r_cb;
    logic [31:0]        r_low;
    logic [31:0]        r_high;
    logic [31:0]        r_r;
    logic [3:0]         r_step;
    logic [2:0]         r_nb;
    logic [15:0]        r_rem [2];
    logic [14:0]        r_den [2];
    logic [PROB_W-1:0]  r_quo [2];
    logic [18:0]        r_m1;
    logic [18:0]        r_m2;
    logic [11:0]        r_prob;
    logic [31:0]        r_ph;
    logic [11:0]        r_pl;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;

    logic               out_free;
    logic [15:0]        d_t   [2];
    logic               d_ge  [2];
    logic [PROB_W-1:0]  p_a;
    logic [PROB_W-1:0]  p_b;
    logic [5:0]         w_a;
    logic [18:0]        bsum;
    logic [13:0]        bq;
    logic [31:0]        mid;
    logic               rn_go;
    logic [31:0]        nl;
    logic [31:0]        nh;
    logic               rn_more;
    t_pair              upd_a;
    t_pair              upd_b;

    assign out_free = !r_out_valid || i_tready;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_byte;
    assign o_tlast  = r_out_last;
    assign w_a      = 6'(WEIGHT_FULL) - {1'b0, r_job.wgt};

    // divider lanes: first step compares c1, then 12 shift-subtract steps
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            d_t[i]  = (r_step == 4'd0) ? r_rem[i] : {r_rem[i][14:0], 1'b0};
            d_ge[i] = (d_t[i] >= {1'b0, r_den[i]});
        end
    end

    always_comb begin
        p_a  = (r_den[0] == 15'd0) ? PROB_W'(PROB_ONE / 2) : r_quo[0];
        p_b  = (r_den[1] == 15'd0) ? PROB_W'(PROB_ONE / 2) : r_quo[1];
        bsum = r_m1 + r_m2 + 19'(WEIGHT_FULL / 2);
        bq   = bsum[18:5];
        mid  = r_low + r_ph + 32'(r_pl);
        rn_go   = (r_nb < 3'd4) && (r_low[31:24] == r_high[31:24]);
        nl      = {r_low[23:0], 8'h00};
        nh      = {r_high[23:0], 8'hFF};
        rn_more = (r_nb < 3'd3) && (nl[31:24] == nh[31:24]);
        upd_a   = cnt_update(r_ca, r_job.bin, w_a);
        upd_b   = cnt_update((r_job.idx_b == r_job.idx_a) ? r_ca : r_cb, r_job.bin,
                             {1'b0, r_job.wgt});
    end

    always_comb begin
        rd_addr = (r_state == S_RDA) ? r_job.idx_a : r_job.idx_b;
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = '{c1: CNT_W'(CNT_INIT), c0: CNT_W'(CNT_INIT)};
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_UPDA: begin
                wr_en   = 1'b1;
                wr_addr = r_job.idx_a;
                wr_data = upd_a;
            end
            S_UPDB: begin
                wr_en   = 1'b1;
                wr_addr = r_job.idx_b;
                wr_data = upd_b;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr == ENTRY_W'(ENTRY_COUNT - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.func == FUNC_FLUSH) ? S_FLUSH : S_RDA;
                end
            end
            S_RDA:    n_state = S_RDB;
            S_RDB:    n_state = S_DINIT;
            S_DINIT:  n_state = S_DIV;
            S_DIV:    if (r_step == 4'd12) n_state = S_MUL;
            S_MUL:    n_state = S_BLEND;
            S_BLEND:  n_state = S_SPLIT;
            S_SPLIT:  n_state = S_MID;
            S_MID:    n_state = S_RENORM;
            S_RENORM: if (!rn_go) n_state = S_UPDA;
            S_UPDA:   n_state = S_UPDB;
            S_UPDB:   n_state = S_IDLE;
            S_FLUSH:  if (out_free && r_nb == 3'd3) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_r   <= r_high - r_low;
                r_nb  <= 3'd0;
            end
            S_RDB: begin
                r_ca <= r_rd_data;
            end
            S_DINIT: begin
                r_cb     <= r_rd_data;
                r_den[0] <= {1'b0, r_ca.c0} + {1'b0, r_ca.c1};
                r_den[1] <= {1'b0, r_rd_data.c0} + {1'b0, r_rd_data.c1};
                r_rem[0] <= {2'b0, r_ca.c1};
                r_rem[1] <= {2'b0, r_rd_data.c1};
                r_step   <= 4'd0;
            end
            S_DIV: begin
                for (int i = 0; i < 2; i++) begin
                    r_rem[i] <= d_ge[i] ? (d_t[i] - {1'b0, r_den[i]}) : d_t[i];
                    r_quo[i] <= {r_quo[i][PROB_W-2:0], d_ge[i]};
                end
                r_step <= r_step + 4'd1;
            end
            S_MUL: begin
                r_m1 <= 19'(p_a) * 19'(w_a);
                r_m2 <= 19'(p_b) * 19'(r_job.wgt);
            end
            S_BLEND: begin
                if (bq == 14'd0) begin
                    r_prob <= 12'd1;
                end else if (bq > 14'(PROB_ONE - 1)) begin
                    r_prob <= 12'(PROB_ONE - 1);
                end else begin
                    r_prob <= bq[11:0];
                end
            end
            S_SPLIT: begin
                r_ph <= 32'(r_r[31:12]) * 32'(r_prob);
                r_pl <= 12'((24'(r_r[11:0]) * 24'(r_prob)) >> 12);
            end
            S_UPDA: begin
                r_ca <= upd_a;
            end
            default: begin
            end
        endcase
        if (r_state == S_RENORM && rn_go && out_free) begin
            r_out_byte <= r_high[31:24];
            r_out_last <= !rn_more;
            r_nb       <= r_nb + 3'd1;
        end else if (r_state == S_FLUSH && out_free) begin
            r_out_byte <= r_low[31:24];
            r_out_last <= (r_nb == 3'd3);
            r_nb       <= r_nb + 3'd1;
        end

        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_low       <= 32'h0;
            r_high      <= 32'hFFFF_FFFF;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_MID) begin
                if (r_job.bin) begin
                    r_high <= mid;
                end else begin
                    r_low <= mid + 32'd1;
                end
            end else if (r_state == S_RENORM && rn_go && out_free) begin
                r_low  <= nl;
                r_high <= nh;
            end else if (r_state == S_FLUSH && out_free) begin
                if (r_nb == 3'd3) begin
                    r_low  <= 32'h0;
                    r_high <= 32'hFFFF_FFFF;
                end else begin
                    r_low <= nl;
                end
            end
            if ((r_state == S_RENORM && rn_go && out_free) ||
                (r_state == S_FLUSH && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- bench/mcbae_checker.sv -----
// Stream checker for the mixed-count binary arithmetic encoder: predicts the
// output byte stream from accepted input transactions and compares. Uses mcbae_pkg.
`default_nettype none

module mcbae_checker import mcbae_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,
    input  wire logic        m_axis_tlast,
    output int               o_errors,
    output int               o_pending,
    output int               o_bytes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte;

    t_byte        byte_queue[$];
    logic [31:0]  lo_bound;
    logic [31:0]  hi_bound;
    int unsigned  zero_cnt[ENTRY_COUNT];
    int unsigned  one_cnt[ENTRY_COUNT];

    function automatic int unsigned estimate(int unsigned idx);
        int unsigned s;
        s = zero_cnt[idx] + one_cnt[idx];
        if (s == 0) return PROB_ONE / 2;
        return (PROB_ONE * one_cnt[idx]) / s;
    endfunction

    function automatic void adapt(int unsigned idx, logic bit_v, int unsigned wt);
        int unsigned c0;
        int unsigned c1;
        c0 = zero_cnt[idx];
        c1 = one_cnt[idx];
        if (bit_v) c1 += wt;
        else c0 += wt;
        if (c0 + c1 > HALVE_LIMIT) begin
            c0 = (c0 + 1) >> 1;
            c1 = (c1 + 1) >> 1;
        end
        zero_cnt[idx] = c0 & 32'h3fff;
        one_cnt[idx]  = c1 & 32'h3fff;
    endfunction

    task automatic encode_transaction(logic func, logic [23:0] d);
        logic        bit_v;
        int unsigned ia;
        int unsigned ib;
        int unsigned w;
        int unsigned p;
        logic [31:0] r;
        logic [31:0] mid;
        int          n;
        bit_v = d[0];
        ia = d[4:1] * NODES_PER_ROW + d[16:9];
        ib = d[8:5] * NODES_PER_ROW + d[16:9];
        w  = d[21:17];
        n  = 0;
        if (func == FUNC_FLUSH) begin
            for (int k = 0; k < 4; k++)
                byte_queue.push_back('{lo_bound[31-8*k -: 8], k == 3});
            lo_bound = '0;
            hi_bound = '1;
            return;
        end
        p = (estimate(ia) * (WEIGHT_FULL - w) + estimate(ib) * w + WEIGHT_FULL / 2)
            / WEIGHT_FULL;
        if (p < 1) p = 1;
        if (p > PROB_ONE - 1) p = PROB_ONE - 1;
        r   = hi_bound - lo_bound;
        mid = lo_bound + (r >> 12) * p + (((r & 32'hfff) * p) >> 12);
        if (bit_v) hi_bound = mid;
        else lo_bound = mid + 1;
        while (n < 4 && ((lo_bound ^ hi_bound) & 32'hff000000) == 0) begin
            byte_queue.push_back('{hi_bound[31:24], 1'b0});
            n++;
            lo_bound = lo_bound << 8;
            hi_bound = (hi_bound << 8) | 32'hff;
        end
        if (n > 0) byte_queue[byte_queue.size()-1].last = 1'b1;
        adapt(ia, bit_v, WEIGHT_FULL - w);
        adapt(ib, bit_v, w);
    endtask

    initial begin
        lo_bound = '0;
        hi_bound = '1;
        foreach (zero_cnt[i]) begin
            zero_cnt[i] = CNT_INIT;
            one_cnt[i]  = CNT_INIT;
        end
        o_errors  = 0;
        o_bytes   = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_byte exp_b;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                encode_transaction(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                o_bytes <= o_bytes + 1;
                if (byte_queue.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("unexpected byte %02h last %0b", m_axis_tdata, m_axis_tlast);
                end else begin
                    exp_b = byte_queue.pop_front();
                    if (exp_b.data !== m_axis_tdata || exp_b.last !== m_axis_tlast) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("byte mismatch: expected %02h/%0b got %02h/%0b",
                                     exp_b.data, exp_b.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
        end
        o_pending <= byte_queue.size();
    end
endmodule

`default_nettype wire

// ----- bench/tb_mixed_count_binary_arith_encoder.sv -----
// Testbench top for mixed_count_binary_arith_encoder: drives directed and
// random coding/flush transactions with random idling. Uses mcbae_checker.
`default_nettype none

module tb_mixed_count_binary_arith_encoder;
    import mcbae_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000; // covers the store sweep after reset

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;  // bin[0], row_a[4:1], row_b[8:5], node[16:9], wgt[21:17]
    logic        s_axis_tuser;  // func[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;  // out_byte[7:0]
    logic        m_axis_tlast;

    int  errors, pending, bytes_seen;
    int  items_sent;
    int  idle_cycles;
    bit  calm;       // final stretch: no idling
    bit  hold_sink;  // long receiver hold-off

    mixed_count_binary_arith_encoder i_dut (.*);

    mcbae_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .m_axis_tlast, .o_errors(errors), .o_pending(pending), .o_bytes(bytes_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // one transaction; waits for the handshake, with an optional idle burst first
    task automatic send(logic func, logic bin, logic [3:0] ra, logic [3:0] rb,
                        logic [7:0] node, logic [4:0] wgt);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {2'b00, wgt, node, rb, ra, bin};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic code_random(bit hot);
        // hot: narrow set of entries, so the same counts keep adapting
        send(FUNC_CODE, $urandom_range(0, 1),
             hot ? 4'($urandom_range(0, 1)) : 4'($urandom),
             hot ? 4'($urandom_range(0, 1)) : 4'($urandom),
             hot ? 8'($urandom_range(0, 2)) : 8'($urandom),
             5'($urandom_range(0, 31)));
    endtask

    // receiver: random stall bursts, a long hold-off on request, none at the end
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("mixed_count_binary_arith_encoder verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        idle_cycles = 0;
        items_sent = 0;
        calm = 0;
        hold_sink = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, both bins, weight edges, shared entries, flushes
        send(FUNC_FLUSH, 1'b0, 4'd0, 4'd0, 8'd0, 5'd0);          // flush of a fresh range
        send(FUNC_CODE, 1'b1, 4'd0, 4'd0, 8'd0, 5'd0);
        send(FUNC_CODE, 1'b0, 4'd15, 4'd15, 8'd255, 5'd31);
        send(FUNC_CODE, 1'b1, 4'd15, 4'd0, 8'd255, 5'd16);
        send(FUNC_CODE, 1'b0, 4'd3, 4'd3, 8'd7, 5'd0);           // same entry twice
        send(FUNC_CODE, 1'b1, 4'd5, 4'd10, 8'd170, 5'd21);
        send(FUNC_CODE, 1'b0, 4'd10, 4'd5, 8'd85, 5'd10);
        for (int k = 0; k < 8; k++)                               // long run of ones
            send(FUNC_CODE, 1'b1, 4'd1, 4'd2, 8'd9, 5'd31);
        for (int k = 0; k < 6; k++)
            send(FUNC_CODE, 1'b0, 4'd1, 4'd2, 8'd9, 5'd1);
        send(FUNC_FLUSH, 1'b1, 4'd15, 4'd15, 8'd255, 5'd31);
        send(FUNC_CODE, 1'b1, 4'd1, 4'd2, 8'd9, 5'd16);
        send(FUNC_FLUSH, 1'b0, 4'd0, 4'd0, 8'd0, 5'd0);

        // receiver holds off while the sender keeps offering
        hold_sink = 1;
        fork
            repeat (30) code_random(1'b0);
            repeat (400) @(posedge i_clk);
        join_any
        hold_sink = 0;
        wait fork;

        // random: mostly coding, with a share on a few hot entries
        for (int k = 0; k < 265; k++) begin
            if (k >= 215) calm = 1;
            if ($urandom_range(0, 24) == 0)
                send(FUNC_FLUSH, 1'($urandom), 4'($urandom), 4'($urandom),
                     8'($urandom), 5'($urandom));
            else
                code_random($urandom_range(0, 2) == 0);
        end
        send(FUNC_FLUSH, 1'b0, 4'd0, 4'd0, 8'd0, 5'd0);
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Sent %0d transactions (coding and flush), checked %0d output bytes.",
                 items_sent, bytes_seen);
        if (errors == 0)
            $display("mixed_count_binary_arith_encoder verification clean");
        else
            $display("mixed_count_binary_arith_encoder verification failed");
        $finish;
    end
endmodule

`default_nettype wire
